### rtl/psgc_pkg.sv
// Shared types and constants for the per-stream sequence gap checker.
// Used by psgc_cell and per_stream_sequence_gap_checker_unit.
`default_nettype none

package psgc_pkg;

    // Field widths
    localparam int CODE_W   = 64;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 3;

    // Default table depth
    localparam int MAX_STREAMS_DEF = 16;

    // Count increment, wraps mod 16
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_IN_ORDER = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISSED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    // One header moving down the cell chain, with its result so far
    typedef struct packed {
        logic [CODE_W-1:0]   code;
        logic [COUNT_W-1:0]  count;
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  exp;
    } item_t;

endpackage

`default_nettype wire

### rtl/per_stream_sequence_gap_checker_unit.sv
// Top level of the per-stream sequence gap checker: a chain of psgc_cell entries.
// Depends on psgc_pkg and psgc_cell.
//
//  Channel  Signals                                       Direction
//  item     item_valid, item_stall, stream_code,          in
//           seq_count, header_ok
//  result   result_valid, result_stall, status,           out
//           expected_count, accepted
//
// One header enters per cycle unless a held result stalls the chain.
// Each header passes through every cell; each cell is one stage and one table entry.
// The whole chain moves together; a stalled result holds every stage and stalls the input.
// Reset clears the valid bits of all stages and the used flags of all entries at once.
`default_nettype none

module per_stream_sequence_gap_checker_unit #(
    parameter int MAX_STREAMS = psgc_pkg::MAX_STREAMS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_stall,
    input  wire logic [psgc_pkg::CODE_W-1:0]   stream_code,
    input  wire logic [psgc_pkg::COUNT_W-1:0]  seq_count,
    input  wire logic                          header_ok,
    output logic                               result_valid,
    input  wire logic                          result_stall,
    output logic [psgc_pkg::STATUS_W-1:0]      status,
    output logic [psgc_pkg::COUNT_W-1:0]       expected_count,
    output logic                               accepted
);
    import psgc_pkg::*;

    localparam logic [MAX_STREAMS-1:0] USED_ONE = MAX_STREAMS'(1);

    logic                   advance;
    logic [MAX_STREAMS:0]   chain_valid;
    item_t                  chain_item [0:MAX_STREAMS];
    logic [MAX_STREAMS-1:0] used_vec;

    // Chain moves unless the result at the tail is held
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    // Item entry: invalid headers are settled here, others default to table full
    assign chain_valid[0]       = item_valid;
    assign chain_item[0].code   = stream_code;
    assign chain_item[0].count  = seq_count;
    assign chain_item[0].done   = !header_ok;
    assign chain_item[0].status = header_ok ? ST_FULL : ST_INVALID;
    assign chain_item[0].exp    = header_ok ? seq_count : '0;

    // Row of entry cells
    for (genvar i = 0; i < MAX_STREAMS; i++)
    begin : g_cell
        psgc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .prev_valid (chain_valid[i]),
            .prev_item  (chain_item[i]),
            .next_valid (chain_valid[i+1]),
            .next_item  (chain_item[i+1]),
            .used       (used_vec[i])
        );
    end

    // Tail stage is the result register
    assign result_valid   = chain_valid[MAX_STREAMS];
    assign status         = chain_item[MAX_STREAMS].status;
    assign expected_count = chain_item[MAX_STREAMS].exp;
    assign accepted       = (chain_item[MAX_STREAMS].status != ST_INVALID);

    // Entries fill from index zero and are never freed
    a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((used_vec + USED_ONE) & used_vec) == '0)
        else $error("used entries are not a prefix");

    // At most one entry is claimed per cycle
    a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(used_vec) <= $countones($past(used_vec)) + 1)
        else $error("more than one entry claimed in a cycle");

    // A held result freezes the table
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(used_vec))
        else $error("table changed while result held");

    // Rejected headers come out only with the invalid status
    a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (accepted == (status != ST_INVALID)))
        else $error("accepted flag does not match status");

endmodule

`default_nettype wire

### rtl/psgc_cell.sv
// One table entry of the gap checker plus one pipeline stage of the chain.
// Depends on psgc_pkg for item_t and the status codes.
`default_nettype none

module psgc_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           prev_valid,
    input  wire psgc_pkg::item_t prev_item,
    output logic                next_valid,
    output psgc_pkg::item_t     next_item,
    output logic                used
);
    import psgc_pkg::*;

    logic               used_reg;
    logic [CODE_W-1:0]  key_reg;
    logic [COUNT_W-1:0] nexp_reg;
    logic               valid_reg;
    item_t              item_reg;
    item_t              item_next;
    logic               take;
    logic               hit;
    logic               claim;

    // Match against this entry; a free entry is the first free one (used is a prefix)
    assign take  = prev_valid && !prev_item.done;
    assign hit   = take && used_reg && (key_reg == prev_item.code);
    assign claim = take && !used_reg;

    // Result update for the passing item
    always_comb
    begin
        item_next = prev_item;
        if (hit)
        begin
            item_next.done   = 1'b1;
            item_next.exp    = nexp_reg;
            item_next.status = (nexp_reg == prev_item.count) ? ST_IN_ORDER : ST_MISSED;
        end
        else if (claim)
        begin
            item_next.done   = 1'b1;
            item_next.exp    = prev_item.count;
            item_next.status = ST_NEW;
        end
    end

    // Entry state and stage valid: used flag and valid bit cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev_valid;
            if (claim)
            begin
                used_reg <= 1'b1;
            end
        end
    end

    // Entry payload and stage payload, no reset
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            item_reg <= item_next;
            if (claim)
            begin
                key_reg <= prev_item.code;
            end
            if (hit || claim)
            begin
                nexp_reg <= prev_item.count + COUNT_ONE;
            end
        end
    end

    assign next_valid = valid_reg;
    assign next_item  = item_reg;
    assign used       = used_reg;

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for per_stream_sequence_gap_checker_unit.
// Drives packet header summaries, predicts each status from its own stream table.
// Depends on psgc_pkg and the RTL of the checker.

module tb_top;

    import psgc_pkg::*;

    localparam int TABLE_DEPTH    = MAX_STREAMS_DEF;
    localparam int RANDOM_HEADERS = 1225;
    localparam int HOLD_CYCLES    = 150;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
        logic               ok;
    } header_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  exp_count;
        logic                accepted;
    } verdict_t;

    // Clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #6 clk = ~clk;

    // Block ports; the inputs are all known from time zero
    logic                item_valid     = 1'b0;
    logic                item_stall;
    logic [CODE_W-1:0]   stream_code    = '0;
    logic [COUNT_W-1:0]  seq_count      = '0;
    logic                header_ok      = 1'b0;
    logic                result_valid;
    logic                result_stall   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  expected_count;
    logic                accepted;

    per_stream_sequence_gap_checker_unit #(
        .MAX_STREAMS(TABLE_DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .stream_code   (stream_code),
        .seq_count     (seq_count),
        .header_ok     (header_ok),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status        (status),
        .expected_count(expected_count),
        .accepted      (accepted)
    );

    // Testbench state
    header_t            headers_to_send[$];
    verdict_t           verdicts_due[$];
    logic [CODE_W-1:0]  stream_pool[TABLE_DEPTH];
    logic [COUNT_W-1:0] gen_next_count[logic [CODE_W-1:0]];
    int                 total_headers = 0;
    int                 headers_taken = 0;
    int                 mismatches    = 0;
    int                 cycle_count   = 0;
    int                 send_idle     = 0;
    int                 stall_left    = 0;
    int                 hold_left     = 0;
    int                 holds_done    = 0;
    logic               hold_off      = 1'b0;
    logic               quiet_phase;

    // Predicted stream table
    logic [CODE_W-1:0]  tbl_key[TABLE_DEPTH];
    logic               tbl_used[TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_next[TABLE_DEPTH];

    // Periodic stretches with no idling on either side
    assign quiet_phase = (cycle_count % 1024) < 160;

    function automatic logic [CODE_W-1:0] rand_code();
        return {$urandom, $urandom};
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(3, 1);
        return $urandom_range(45, 12);
    endfunction

    // Queue a header and remember where its stream's count should go next
    task automatic queue_header(input logic [CODE_W-1:0] code, input logic [COUNT_W-1:0] cnt,
                                input logic ok);
        header_t h;
        h.code  = code;
        h.count = cnt;
        h.ok    = ok;
        headers_to_send = {headers_to_send, h};
        total_headers++;
        if (ok)
            gen_next_count[code] = cnt + COUNT_ONE;
    endtask

    // Stream table lookup and update for one accepted header
    task automatic track_stream_header(input logic [CODE_W-1:0] code,
                                       input logic [COUNT_W-1:0] cnt, input logic ok);
        verdict_t v;
        int       hit;
        int       free_slot;
        hit       = -1;
        free_slot = -1;
        v.status    = ST_INVALID;
        v.exp_count = '0;
        v.accepted  = 1'b0;
        if (ok)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (tbl_used[i])
                begin
                    if (hit < 0 && tbl_key[i] == code)
                        hit = i;
                end
                else if (free_slot < 0)
                    free_slot = i;
            end
            v.accepted = 1'b1;
            if (hit >= 0)
            begin
                v.exp_count   = tbl_next[hit];
                v.status      = (tbl_next[hit] == cnt) ? ST_IN_ORDER : ST_MISSED;
                tbl_next[hit] = cnt + COUNT_ONE;
            end
            else if (free_slot >= 0)
            begin
                tbl_used[free_slot] = 1'b1;
                tbl_key[free_slot]  = code;
                tbl_next[free_slot] = cnt + COUNT_ONE;
                v.status            = ST_NEW;
                v.exp_count         = cnt;
            end
            else
            begin
                v.status    = ST_FULL;
                v.exp_count = cnt;
            end
        end
        verdicts_due = {verdicts_due, v};
    endtask

    // Cycle counter and run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Header driver: one transfer per valid/not-stalled edge, payload held while stalled
    always @(posedge clk or negedge rst_n)
    begin
        header_t h;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            send_idle = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                track_stream_header(stream_code, seq_count, header_ok);
                headers_taken++;
                send_idle = (hold_off || quiet_phase) ? 0 : pick_idle_len();
            end
            if (item_valid && item_stall)
            begin
                // stalled: keep the same transfer on the bus
            end
            else if (send_idle > 0)
            begin
                send_idle--;
                item_valid <= 1'b0;
            end
            else if (headers_to_send.size() > 0)
            begin
                h = headers_to_send.pop_front();
                item_valid  <= 1'b1;
                stream_code <= h.code;
                seq_count   <= h.count;
                header_ok   <= h.ok;
            end
            else
                item_valid <= 1'b0;
        end
    end

    // Long receiver hold-off, twice in the run, so the pipeline fills and backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off <= 1'b0;
            hold_left  = 0;
            holds_done = 0;
        end
        else
        begin
            if (hold_left == 0 && ((holds_done == 0 && headers_taken >= 300) ||
                                   (holds_done == 1 && headers_taken >= 900)))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_off <= 1'b1;
            end
            else
                hold_off <= 1'b0;
        end
    end

    // Random receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (hold_off)
            result_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
            stall_left = quiet_phase ? 0 : pick_idle_len();
        end
    end

    // Result monitor: compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("result transfer with no prediction pending: status %0d", status);
                mismatches++;
            end
            else
            begin
                v = verdicts_due.pop_front();
                if (status !== v.status)
                begin
                    $error("status: expected %0d, got %0d", v.status, status);
                    mismatches++;
                end
                if (expected_count !== v.exp_count)
                begin
                    $error("expected_count: expected %0d, got %0d", v.exp_count,
                           expected_count);
                    mismatches++;
                end
                if (accepted !== v.accepted)
                begin
                    $error("accepted: expected %0d, got %0d", v.accepted, accepted);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [CODE_W-1:0]  code;
        logic [CODE_W-1:0]  stray;
        logic [COUNT_W-1:0] cnt;
        int                 r;
        int                 k;

        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i]  = '0;
            tbl_next[i] = '0;
        end
        stream_pool[0] = '0;
        stream_pool[1] = '1;
        for (int i = 2; i < TABLE_DEPTH; i++)
            stream_pool[i] = rand_code();

        // Directed: invalid, new, in order, gap, count wrap, invalid leaves table alone
        queue_header('1, 4'hF, 1'b0);
        queue_header('0, 4'd0, 1'b1);
        queue_header('0, 4'd1, 1'b1);
        queue_header('0, 4'd5, 1'b1);
        queue_header('1, 4'hF, 1'b1);
        queue_header('1, 4'd0, 1'b1);
        queue_header('0, 4'd9, 1'b0);
        queue_header('0, 4'd6, 1'b1);
        // fill the table, then a new stream has no room, twice
        for (int i = 2; i < TABLE_DEPTH; i++)
            queue_header(stream_pool[i], 4'($urandom), 1'b1);
        stray = rand_code();
        queue_header(stray, 4'hF, 1'b1);
        queue_header(stray, 4'd0, 1'b1);
        queue_header('1, 4'd7, 1'b1);

        // Random: mostly in-order runs on tracked streams, some gaps, invalids, strays
        for (int n = 0; n < RANDOM_HEADERS; n++)
        begin
            r = $urandom_range(99);
            if (r < 8)
                queue_header(rand_code(), 4'($urandom), 1'b0);
            else if (r < 16)
                queue_header(rand_code(), 4'($urandom), 1'b1);
            else
            begin
                k    = $urandom_range(TABLE_DEPTH - 1);
                code = stream_pool[k];
                if (gen_next_count.exists(code) && $urandom_range(9) < 8)
                    cnt = gen_next_count[code];
                else
                    cnt = 4'($urandom);
                queue_header(code, cnt, 1'b1);
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (headers_taken < total_headers)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (4 * TABLE_DEPTH) @(posedge clk);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
